// ===== rtl/http_request_head_parser_macros.svh =====
// Assertion macros shared by the request head parser RTL.
// No dependencies; included by the modules that carry checks.
`ifndef HTTP_REQUEST_HEAD_PARSER_MACROS_SVH
`define HTTP_REQUEST_HEAD_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define HRHP_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("hrhp: same-cycle check failed");
`define HRHP_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("hrhp: next-cycle check failed");
`define HRHP_ASSERT_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error("hrhp: forbidden condition seen");
`else
`define HRHP_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define HRHP_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`define HRHP_ASSERT_NEVER(lbl, ck, rn, cond)
`endif
`endif

// ===== rtl/hrhp_pkg.sv =====
// Shared types and constants of the HTTP request head parser.
// No dependencies; used by every module of the block.
package hrhp_pkg;

    localparam logic [11:0] URL_LIMIT_MAX   = 12'd4094;
    localparam logic [11:0] URL_LIMIT_RESET = 12'd1022;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    localparam logic [2:0] EV_ABSORBED = 3'd0;
    localparam logic [2:0] EV_METHOD   = 3'd1;
    localparam logic [2:0] EV_URL_BYTE = 3'd2;
    localparam logic [2:0] EV_URL_END  = 3'd3;
    localparam logic [2:0] EV_LINE     = 3'd4;
    localparam logic [2:0] EV_HDR_END  = 3'd5;
    localparam logic [2:0] EV_ERROR    = 3'd6;

    localparam logic [1:0] ERR_BAD_METHOD = 2'd0;
    localparam logic [1:0] ERR_URL_LONG   = 2'd1;
    localparam logic [1:0] ERR_URL_EOL    = 2'd2;
    localparam logic [1:0] ERR_LITERAL    = 2'd3;

    localparam logic METHOD_GET  = 1'b0;
    localparam logic METHOD_HEAD = 1'b1;

    // Classified input byte handed from the front to the engine.
    typedef struct packed {
        logic [7:0] raw;
        logic [7:0] up;
        logic       is_cr;
        logic       is_lf;
        logic       is_sp;
    } cls_t;

    // One result word.
    typedef struct packed {
        logic [2:0]  ev;
        logic        method;
        logic [7:0]  url_byte;
        logic [11:0] url_length;
        logic [7:0]  major;
        logic [7:0]  minor;
        logic [1:0]  err;
    } res_t;

endpackage

// ===== rtl/hrhp_front.sv =====
// Front stage: registers an input byte and classifies it.
// Depends on hrhp_pkg.
module hrhp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        byte_in,
    output logic              wr_en,
    output hrhp_pkg::cls_t    wr_item,
    input  logic              q_full
);

    logic           valid_reg;
    logic           valid_next;
    hrhp_pkg::cls_t item_reg;
    hrhp_pkg::cls_t item_next;
    logic           take;

    assign full  = valid_reg && q_full;
    assign take  = push && !full;
    assign wr_en = valid_reg && !q_full;
    assign wr_item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next = 1'b1;
        end
        item_next.raw   = byte_in;
        item_next.up    = byte_in;
        if (byte_in >= hrhp_pkg::CH_LOW_A && byte_in <= hrhp_pkg::CH_LOW_Z)
        begin
            item_next.up = byte_in - hrhp_pkg::CASE_GAP;
        end
        item_next.is_cr = (byte_in == hrhp_pkg::CH_CR);
        item_next.is_lf = (byte_in == hrhp_pkg::CH_LF);
        item_next.is_sp = (byte_in == hrhp_pkg::CH_SP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/hrhp_queue.sv =====
// Two-entry queue of classified bytes between front and engine.
// Depends on hrhp_pkg and the assertion macro header.
`include "http_request_head_parser_macros.svh"
module hrhp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  hrhp_pkg::cls_t wr_item,
    output logic           full,
    input  logic           rd_en,
    output hrhp_pkg::cls_t rd_item,
    output logic           empty
);

    hrhp_pkg::cls_t mem [2];
    logic       wp_reg;
    logic       wp_next;
    logic       rp_reg;
    logic       rp_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_item = mem[rp_reg];

    always_comb
    begin
        wp_next    = wr_en ? ~wp_reg : wp_reg;
        rp_next    = rd_en ? ~rp_reg : rp_reg;
        count_next = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_item;
        end
    end

    `HRHP_ASSERT_NEVER(a_q_overflow, clk, rst_n, wr_en && full && !rd_en)
    `HRHP_ASSERT_NEVER(a_q_underflow, clk, rst_n, rd_en && empty)
    `HRHP_ASSERT_NEXT(a_q_lone_push, clk, rst_n, wr_en && !rd_en && empty, !empty)

endmodule

// ===== rtl/hrhp_engine.sv =====
// Back stage: request-line state machine, limit register and result buffer.
// Depends on hrhp_pkg and the assertion macro header.
`include "http_request_head_parser_macros.svh"
module hrhp_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [11:0]    cfg_data,
    input  logic           q_empty,
    input  hrhp_pkg::cls_t q_item,
    output logic           q_pop,
    output logic           empty,
    input  logic           pop,
    output hrhp_pkg::res_t head
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_G_E, PH_G_T, PH_G_SP, PH_H_E, PH_H_A, PH_H_D, PH_H_SP,
        PH_URL, PH_L_H, PH_L_T1, PH_L_T2, PH_L_P, PH_L_SL, PH_MAJ, PH_DOT,
        PH_MIN, PH_CR, PH_LF, PH_HDR
    } phase_t;

    typedef enum logic [2:0] {
        LE_NONE, LE_CR1, LE_LF1, LE_CR2, LE_LF2
    } le_t;

    phase_t         phase_reg;
    phase_t         phase_next;
    le_t            le_reg;
    le_t            le_next;
    logic           method_reg;
    logic           method_next;
    logic [11:0]    url_count_reg;
    logic [11:0]    url_count_next;
    logic [7:0]     major_reg;
    logic [7:0]     major_next;
    logic [7:0]     minor_reg;
    logic [7:0]     minor_next;
    logic [11:0]    url_limit_reg;
    logic [11:0]    lim;

    // literal match decode
    logic           exp_en;
    logic [7:0]     exp_want;
    phase_t         exp_to;
    logic [1:0]     exp_code;
    logic           exp_ok;

    hrhp_pkg::res_t res;

    hrhp_pkg::res_t out_mem [2];
    logic           out_wp_reg;
    logic           out_rp_reg;
    logic [1:0]     out_count_reg;
    logic [1:0]     out_count_next;
    logic           out_pop;

    assign lim     = (url_limit_reg < hrhp_pkg::URL_LIMIT_MAX) ? url_limit_reg
                                                               : hrhp_pkg::URL_LIMIT_MAX;
    assign q_pop   = !q_empty && (out_count_reg != 2'd2);
    assign empty   = (out_count_reg == 2'd0);
    assign out_pop = pop && !empty;
    assign head    = out_mem[out_rp_reg];
    assign exp_ok  = (q_item.up == exp_want);

    always_comb
    begin
        exp_en   = 1'b1;
        exp_want = hrhp_pkg::CH_SP;
        exp_to   = PH_URL;
        exp_code = hrhp_pkg::ERR_LITERAL;
        case (phase_reg)
            PH_G_E:  begin exp_want = hrhp_pkg::CH_E;     exp_to = PH_G_T;
                           exp_code = hrhp_pkg::ERR_BAD_METHOD; end
            PH_G_T:  begin exp_want = hrhp_pkg::CH_T;     exp_to = PH_G_SP;
                           exp_code = hrhp_pkg::ERR_BAD_METHOD; end
            PH_H_E:  begin exp_want = hrhp_pkg::CH_E;     exp_to = PH_H_A;
                           exp_code = hrhp_pkg::ERR_BAD_METHOD; end
            PH_H_A:  begin exp_want = hrhp_pkg::CH_A;     exp_to = PH_H_D;
                           exp_code = hrhp_pkg::ERR_BAD_METHOD; end
            PH_H_D:  begin exp_want = hrhp_pkg::CH_D;     exp_to = PH_H_SP;
                           exp_code = hrhp_pkg::ERR_BAD_METHOD; end
            PH_G_SP,
            PH_H_SP: begin exp_want = hrhp_pkg::CH_SP;    exp_to = PH_URL;
                           exp_code = hrhp_pkg::ERR_BAD_METHOD; end
            PH_L_H:  begin exp_want = hrhp_pkg::CH_H;     exp_to = PH_L_T1; end
            PH_L_T1: begin exp_want = hrhp_pkg::CH_T;     exp_to = PH_L_T2; end
            PH_L_T2: begin exp_want = hrhp_pkg::CH_T;     exp_to = PH_L_P;  end
            PH_L_P:  begin exp_want = hrhp_pkg::CH_P;     exp_to = PH_L_SL; end
            PH_L_SL: begin exp_want = hrhp_pkg::CH_SLASH; exp_to = PH_MAJ;  end
            PH_DOT:  begin exp_want = hrhp_pkg::CH_DOT;   exp_to = PH_MIN;  end
            PH_CR:   begin exp_want = hrhp_pkg::CH_CR;    exp_to = PH_LF;   end
            PH_LF:   begin exp_want = hrhp_pkg::CH_LF;    exp_to = PH_HDR;  end
            default: exp_en = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        le_next        = le_reg;
        method_next    = method_reg;
        url_count_next = url_count_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        res            = '0;
        res.ev         = hrhp_pkg::EV_ABSORBED;
        res.err        = hrhp_pkg::ERR_BAD_METHOD;

        if (exp_en)
        begin
            if (exp_ok)
            begin
                phase_next = exp_to;
            end
            else
            begin
                phase_next = PH_IDLE;
                res.ev     = hrhp_pkg::EV_ERROR;
                res.err    = exp_code;
            end
        end

        case (phase_reg)
            PH_IDLE:
            begin
                if (q_item.is_cr || q_item.is_lf)
                begin
                    phase_next = PH_IDLE;
                end
                else if (q_item.up == hrhp_pkg::CH_G)
                begin
                    method_next = hrhp_pkg::METHOD_GET;
                    phase_next  = PH_G_E;
                end
                else if (q_item.up == hrhp_pkg::CH_H)
                begin
                    method_next = hrhp_pkg::METHOD_HEAD;
                    phase_next  = PH_H_E;
                end
                else
                begin
                    res.ev  = hrhp_pkg::EV_ERROR;
                    res.err = hrhp_pkg::ERR_BAD_METHOD;
                end
            end
            PH_G_SP,
            PH_H_SP:
            begin
                if (exp_ok)
                begin
                    res.ev         = hrhp_pkg::EV_METHOD;
                    url_count_next = '0;
                end
            end
            PH_URL:
            begin
                if (q_item.is_sp)
                begin
                    res.ev         = hrhp_pkg::EV_URL_END;
                    res.url_length = url_count_reg;
                    phase_next     = PH_L_H;
                end
                else if (q_item.is_cr || q_item.is_lf)
                begin
                    res.ev     = hrhp_pkg::EV_ERROR;
                    res.err    = hrhp_pkg::ERR_URL_EOL;
                    phase_next = PH_IDLE;
                end
                else if (url_count_reg >= lim)
                begin
                    res.ev     = hrhp_pkg::EV_ERROR;
                    res.err    = hrhp_pkg::ERR_URL_LONG;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    res.ev         = hrhp_pkg::EV_URL_BYTE;
                    res.url_byte   = q_item.raw;
                    url_count_next = url_count_reg + 12'd1;
                end
            end
            PH_MAJ:
            begin
                major_next = q_item.raw;
                phase_next = PH_DOT;
            end
            PH_MIN:
            begin
                minor_next = q_item.raw;
                phase_next = PH_CR;
            end
            PH_LF:
            begin
                if (exp_ok)
                begin
                    res.ev    = hrhp_pkg::EV_LINE;
                    res.major = major_reg;
                    res.minor = minor_reg;
                    le_next   = LE_LF1;
                end
            end
            PH_HDR:
            begin
                if (q_item.is_cr)
                begin
                    le_next = (le_reg == LE_LF1) ? LE_CR2 : LE_CR1;
                end
                else if (q_item.is_lf)
                begin
                    if (le_reg == LE_CR1)
                    begin
                        le_next = LE_LF1;
                    end
                    else if (le_reg == LE_CR2)
                    begin
                        le_next = LE_LF2;
                    end
                    else
                    begin
                        le_next = LE_NONE;
                    end
                end
                else
                begin
                    le_next = LE_NONE;
                end
                if (le_next == LE_LF2)
                begin
                    res.ev     = hrhp_pkg::EV_HDR_END;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        res.method = method_next;
        if (res.ev != hrhp_pkg::EV_ERROR)
        begin
            res.err = hrhp_pkg::ERR_BAD_METHOD;
        end

        out_count_next = out_count_reg + {1'b0, q_pop} - {1'b0, out_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            le_reg        <= LE_LF1;
            method_reg    <= hrhp_pkg::METHOD_GET;
            url_count_reg <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
            url_limit_reg <= hrhp_pkg::URL_LIMIT_RESET;
            out_wp_reg    <= 1'b0;
            out_rp_reg    <= 1'b0;
            out_count_reg <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                url_limit_reg <= cfg_data;
            end
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                le_reg        <= le_next;
                method_reg    <= method_next;
                url_count_reg <= url_count_next;
                major_reg     <= major_next;
                minor_reg     <= minor_next;
                out_wp_reg    <= ~out_wp_reg;
            end
            if (out_pop)
            begin
                out_rp_reg <= ~out_rp_reg;
            end
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_mem[out_wp_reg] <= res;
        end
    end

    `HRHP_ASSERT_NEVER(a_out_over, clk, rst_n, out_count_reg == 2'd3)
    `HRHP_ASSERT_NEXT(a_err_idle, clk, rst_n, q_pop && res.ev == hrhp_pkg::EV_ERROR, phase_reg == PH_IDLE)
    `HRHP_ASSERT_NEXT(a_hend_le, clk, rst_n, q_pop && res.ev == hrhp_pkg::EV_HDR_END, le_reg == LE_LF2)

endmodule

// ===== rtl/http_request_head_parser.sv =====
// An accepted byte is registered in the front, then in the queue; its result word is then
// registered in the output buffer. Throughput: one byte per cycle unless the output buffer
// is full; the engine's single-step state machine sets the pace.
// Reset (rst_n low, asynchronous): parser idle, limit 1022, all queues empty.
// Depends on hrhp_pkg, hrhp_front, hrhp_queue and hrhp_engine.
module http_request_head_parser (
    input  logic        clk,
    input  logic        rst_n,
    // request byte stream
    input  logic        push,
    output logic        full,
    input  logic [7:0]  byte_in,
    // result words
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  event_res,
    output logic        method,
    output logic [7:0]  url_byte,
    output logic [11:0] url_length,
    output logic [7:0]  major_version,
    output logic [7:0]  minor_version,
    output logic [1:0]  error_code,
    // URL limit register, write only
    input  logic        url_limit_we,
    input  logic [11:0] url_limit_wdata
);

    // Front: register each accepted byte and tag it (upper-cased copy,
    // CR/LF/space flags) so the engine sees only narrow compares.
    logic           fq_wr_en;
    hrhp_pkg::cls_t fq_item;
    logic           fq_full;

    // Engine side of the classified-byte queue.
    logic           q_empty;
    logic           q_pop;
    hrhp_pkg::cls_t q_item;

    hrhp_pkg::res_t head;

    hrhp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .byte_in (byte_in),
        .wr_en   (fq_wr_en),
        .wr_item (fq_item),
        .q_full  (fq_full)
    );

    // Short queue: lets the front keep taking bytes while the result side stalls.
    hrhp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fq_wr_en),
        .wr_item (fq_item),
        .full    (fq_full),
        .rd_en   (q_pop),
        .rd_item (q_item),
        .empty   (q_empty)
    );

    // Engine: advance the request-line state machine one byte per word and
    // hold results in a two-word output buffer; it consumes a byte only
    // when the buffer has room, so nothing is dropped under backpressure.
    hrhp_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (url_limit_we),
        .cfg_data (url_limit_wdata),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign event_res     = head.ev;
    assign method        = head.method;
    assign url_byte      = head.url_byte;
    assign url_length    = head.url_length;
    assign major_version = head.major;
    assign minor_version = head.minor;
    assign error_code    = head.err;

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for http_request_head_parser: byte stream in, one result word out.
// Depends on hrhp_pkg and the RTL of the parser; carries its own model of the parser.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Parser phases as the model tracks them. The two "space after method"
    // phases of GET and HEAD behave the same, so they share one phase here.
    typedef enum logic [4:0] {
        P_IDLE, P_GET_E, P_GET_T, P_HEAD_E, P_HEAD_A, P_HEAD_D, P_METH_SP,
        P_URL, P_VER_H, P_VER_T1, P_VER_T2, P_VER_P, P_VER_SLASH,
        P_MAJOR, P_DOT, P_MINOR, P_CR, P_LF, P_HEADER
    } parse_phase_t;

    // Line-end tracker inside the header block.
    typedef enum logic [2:0] {
        EOL_NONE, EOL_CR1, EOL_LF1, EOL_CR2, EOL_LF2
    } eol_state_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  byte_in;
    logic        empty;
    logic        pop;
    logic [2:0]  event_res;
    logic        method;
    logic [7:0]  url_byte;
    logic [11:0] url_length;
    logic [7:0]  major_version;
    logic [7:0]  minor_version;
    logic [1:0]  error_code;
    logic        url_limit_we;
    logic [11:0] url_limit_wdata;

    // Model state: a private copy of everything the parser remembers.
    parse_phase_t phase_q;
    eol_state_t   eol_q;
    logic         method_q;
    logic [11:0]  url_count_q;
    logic [7:0]   major_q;
    logic [7:0]   minor_q;
    logic [11:0]  url_limit_q;

    hrhp_pkg::res_t expected_words[$];   // predicted result words, oldest first
    logic [7:0]     req_bytes[$];        // request being assembled for sending
    int             sent_bytes;
    int             mismatches;
    int             hold_cycles;         // long receiver hold-off, counted down by the popper
    bit             idle_on;             // random idling on both sides

    http_request_head_parser i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .byte_in         (byte_in),
        .empty           (empty),
        .pop             (pop),
        .event_res       (event_res),
        .method          (method),
        .url_byte        (url_byte),
        .url_length      (url_length),
        .major_version   (major_version),
        .minor_version   (minor_version),
        .error_code      (error_code),
        .url_limit_we    (url_limit_we),
        .url_limit_wdata (url_limit_wdata)
    );

    always #4 clk = ~clk;

    // Hard stop in case the block hangs or drops a word.
    initial
    begin
        #10_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= hrhp_pkg::CH_LOW_A && c <= hrhp_pkg::CH_LOW_Z)
               ? c - hrhp_pkg::CASE_GAP : c;
    endfunction

    // Match one literal byte: advance on a hit, drop to idle with an error on a miss.
    task automatic match_char(input logic [7:0] up, input logic [7:0] want,
                              input parse_phase_t nxt, input logic [1:0] code,
                              inout hrhp_pkg::res_t w);
        if (up == want)
        begin
            phase_q = nxt;
        end
        else
        begin
            phase_q = P_IDLE;
            w.ev    = hrhp_pkg::EV_ERROR;
            w.err   = code;
        end
    endtask

    // Advance the model by one accepted byte and return the word it must produce.
    task automatic advance_parser(input logic [7:0] c, output hrhp_pkg::res_t w);
        logic [7:0]  up;
        logic [11:0] lim;
        w   = '0;
        up  = to_upper(c);
        // A register value above the hardware maximum is clamped.
        lim = (url_limit_q < hrhp_pkg::URL_LIMIT_MAX) ? url_limit_q : hrhp_pkg::URL_LIMIT_MAX;
        case (phase_q)
            P_IDLE:
            begin
                // Skip blank lines between requests; the method is latched on
                // its first letter, even if the rest fails later.
                if (c == hrhp_pkg::CH_CR || c == hrhp_pkg::CH_LF)
                begin
                end
                else if (up == hrhp_pkg::CH_G)
                begin
                    method_q = hrhp_pkg::METHOD_GET;
                    phase_q  = P_GET_E;
                end
                else if (up == hrhp_pkg::CH_H)
                begin
                    method_q = hrhp_pkg::METHOD_HEAD;
                    phase_q  = P_HEAD_E;
                end
                else
                begin
                    w.ev  = hrhp_pkg::EV_ERROR;
                    w.err = hrhp_pkg::ERR_BAD_METHOD;
                end
            end
            P_GET_E:  match_char(up, hrhp_pkg::CH_E, P_GET_T, hrhp_pkg::ERR_BAD_METHOD, w);
            P_GET_T:  match_char(up, hrhp_pkg::CH_T, P_METH_SP, hrhp_pkg::ERR_BAD_METHOD, w);
            P_HEAD_E: match_char(up, hrhp_pkg::CH_E, P_HEAD_A, hrhp_pkg::ERR_BAD_METHOD, w);
            P_HEAD_A: match_char(up, hrhp_pkg::CH_A, P_HEAD_D, hrhp_pkg::ERR_BAD_METHOD, w);
            P_HEAD_D: match_char(up, hrhp_pkg::CH_D, P_METH_SP, hrhp_pkg::ERR_BAD_METHOD, w);
            P_METH_SP:
            begin
                match_char(up, hrhp_pkg::CH_SP, P_URL, hrhp_pkg::ERR_BAD_METHOD, w);
                if (w.ev != hrhp_pkg::EV_ERROR)
                begin
                    w.ev        = hrhp_pkg::EV_METHOD;
                    url_count_q = '0;
                end
            end
            P_URL:
            begin
                if (c == hrhp_pkg::CH_SP)
                begin
                    w.ev         = hrhp_pkg::EV_URL_END;
                    w.url_length = url_count_q;
                    phase_q      = P_VER_H;
                end
                else if (c == hrhp_pkg::CH_CR || c == hrhp_pkg::CH_LF)
                begin
                    w.ev    = hrhp_pkg::EV_ERROR;
                    w.err   = hrhp_pkg::ERR_URL_EOL;
                    phase_q = P_IDLE;
                end
                else if (url_count_q >= lim)
                begin
                    w.ev    = hrhp_pkg::EV_ERROR;
                    w.err   = hrhp_pkg::ERR_URL_LONG;
                    phase_q = P_IDLE;
                end
                else
                begin
                    w.ev        = hrhp_pkg::EV_URL_BYTE;
                    w.url_byte  = c;
                    url_count_q = url_count_q + 12'd1;
                end
            end
            P_VER_H:  match_char(up, hrhp_pkg::CH_H, P_VER_T1, hrhp_pkg::ERR_LITERAL, w);
            P_VER_T1: match_char(up, hrhp_pkg::CH_T, P_VER_T2, hrhp_pkg::ERR_LITERAL, w);
            P_VER_T2: match_char(up, hrhp_pkg::CH_T, P_VER_P, hrhp_pkg::ERR_LITERAL, w);
            P_VER_P:  match_char(up, hrhp_pkg::CH_P, P_VER_SLASH, hrhp_pkg::ERR_LITERAL, w);
            P_VER_SLASH:
            begin
                match_char(up, hrhp_pkg::CH_SLASH, P_MAJOR, hrhp_pkg::ERR_LITERAL, w);
            end
            P_MAJOR:
            begin
                major_q = c;
                phase_q = P_DOT;
            end
            P_DOT:    match_char(up, hrhp_pkg::CH_DOT, P_MINOR, hrhp_pkg::ERR_LITERAL, w);
            P_MINOR:
            begin
                minor_q = c;
                phase_q = P_CR;
            end
            P_CR:     match_char(up, hrhp_pkg::CH_CR, P_LF, hrhp_pkg::ERR_LITERAL, w);
            P_LF:
            begin
                match_char(up, hrhp_pkg::CH_LF, P_HEADER, hrhp_pkg::ERR_LITERAL, w);
                if (w.ev != hrhp_pkg::EV_ERROR)
                begin
                    w.ev    = hrhp_pkg::EV_LINE;
                    w.major = major_q;
                    w.minor = minor_q;
                    eol_q   = EOL_LF1;
                end
            end
            P_HEADER:
            begin
                // Swallow header bytes; a CR LF right after a line end closes the head.
                if (c == hrhp_pkg::CH_CR)
                begin
                    eol_q = (eol_q == EOL_LF1) ? EOL_CR2 : EOL_CR1;
                end
                else if (c == hrhp_pkg::CH_LF)
                begin
                    if (eol_q == EOL_CR1)
                    begin
                        eol_q = EOL_LF1;
                    end
                    else if (eol_q == EOL_CR2)
                    begin
                        eol_q = EOL_LF2;
                    end
                    else
                    begin
                        eol_q = EOL_NONE;
                    end
                end
                else
                begin
                    eol_q = EOL_NONE;
                end
                if (eol_q == EOL_LF2)
                begin
                    w.ev    = hrhp_pkg::EV_HDR_END;
                    phase_q = P_IDLE;
                end
            end
            default:
            begin
                phase_q = P_IDLE;
            end
        endcase
        w.method = method_q;
    endtask

    // ------------------------------------------------------------------
    // Byte sender and helpers
    // ------------------------------------------------------------------

    // Offer one byte, hold it until accepted, then log its expected word.
    task automatic send_byte(input logic [7:0] b);
        hrhp_pkg::res_t w;
        @(negedge clk);
        push    <= 1'b1;
        byte_in <= b;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        advance_parser(b, w);
        expected_words.push_back(w);
        sent_bytes++;
        // Random sender gap; push drops for the whole burst.
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(negedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    // Random byte that neither ends nor breaks a URL.
    function automatic logic [7:0] url_char();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == hrhp_pkg::CH_SP || b == hrhp_pkg::CH_CR || b == hrhp_pkg::CH_LF)
        begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    // Hold the input and wait until every expected word is out, plus the pipeline depth.
    task automatic wait_all_results();
        @(negedge clk);
        push <= 1'b0;
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Write the URL limit only with the block drained.
    task automatic set_url_limit(input logic [11:0] value);
        wait_all_results();
        @(negedge clk);
        url_limit_we    <= 1'b1;
        url_limit_wdata <= value;
        @(negedge clk);
        url_limit_we    <= 1'b0;
        url_limit_q      = value;
    endtask

    // Append a literal word to the request, flipping letters to lower case at random.
    task automatic append_word(input string s);
        logic [7:0] c;
        logic [7:0] lc;
        for (int i = 0; i < s.len(); i++)
        begin
            c  = s[i];
            lc = c | hrhp_pkg::CASE_GAP;
            if (lc >= hrhp_pkg::CH_LOW_A && lc <= hrhp_pkg::CH_LOW_Z
                && $urandom_range(0, 1) == 1)
            begin
                c = lc;
            end
            req_bytes.push_back(c);
        end
    endtask

    // Build one request with random content and send it; when broken,
    // corrupt one byte or cut the request short.
    task automatic send_request(input bit broken);
        logic [11:0] eff;
        int          cap;
        int          pos;
        req_bytes.delete();
        repeat ($urandom_range(0, 2))
        begin
            req_bytes.push_back($urandom_range(0, 1) ? hrhp_pkg::CH_CR : hrhp_pkg::CH_LF);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            append_word("GET");
        end
        else
        begin
            append_word("HEAD");
        end
        req_bytes.push_back(hrhp_pkg::CH_SP);
        // Let short limits run over now and then; keep URLs short otherwise.
        eff = (url_limit_q < hrhp_pkg::URL_LIMIT_MAX) ? url_limit_q : hrhp_pkg::URL_LIMIT_MAX;
        cap = (eff < 12) ? eff + 1 : 12;
        repeat ($urandom_range(0, cap)) req_bytes.push_back(url_char());
        req_bytes.push_back(hrhp_pkg::CH_SP);
        append_word("HTTP/");
        req_bytes.push_back(8'($urandom_range(0, 255)));
        req_bytes.push_back(hrhp_pkg::CH_DOT);
        req_bytes.push_back(8'($urandom_range(0, 255)));
        req_bytes.push_back(hrhp_pkg::CH_CR);
        req_bytes.push_back(hrhp_pkg::CH_LF);
        repeat ($urandom_range(0, 2))
        begin
            repeat ($urandom_range(1, 8))
            begin
                // Stray CRs inside header lines exercise the line-end tracker.
                req_bytes.push_back(($urandom_range(0, 9) == 0) ? hrhp_pkg::CH_CR : url_char());
            end
            req_bytes.push_back(hrhp_pkg::CH_CR);
            req_bytes.push_back(hrhp_pkg::CH_LF);
        end
        req_bytes.push_back(hrhp_pkg::CH_CR);
        req_bytes.push_back(hrhp_pkg::CH_LF);
        if (broken)
        begin
            pos = $urandom_range(0, req_bytes.size() - 1);
            if ($urandom_range(0, 1) == 1)
            begin
                req_bytes[pos] = 8'($urandom_range(0, 255));
            end
            else
            begin
                while (req_bytes.size() > pos + 1)
                begin
                    req_bytes.delete(req_bytes.size() - 1);
                end
            end
        end
        foreach (req_bytes[i])
        begin
            send_byte(req_bytes[i]);
        end
    endtask

    function automatic logic [11:0] pick_url_limit();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return 12'd1;
            2:       return 12'($urandom_range(2, 8));
            3:       return 12'hFFF;
            4:       return hrhp_pkg::URL_LIMIT_MAX;
            5:       return hrhp_pkg::URL_LIMIT_RESET;
            6:       return 12'($urandom_range(0, 4095));
            default: return 12'd12;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: popper and checker
    // ------------------------------------------------------------------

    // Drive pop: long hold-off first, then random stall bursts, else pop every cycle.
    initial
    begin : popper
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                pop <= 1'b0;
                hold_cycles--;
            end
            else if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                begin
                    stall_left = $urandom_range(1, 13);
                end
            end
        end
    end

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Compare each popped word against the oldest prediction.
    always @(posedge clk)
    begin : result_check
        hrhp_pkg::res_t want;
        if (rst_n === 1'b1 && pop === 1'b1 && empty === 1'b0)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: result word with nothing expected, expected none, actual event_res %0d",
                         $time, event_res);
                mismatches++;
            end
            else
            begin
                want = expected_words.pop_front();
                report_field("event_res", want.ev, event_res);
                report_field("method", want.method, method);
                report_field("url_byte", want.url_byte, url_byte);
                report_field("url_length", want.url_length, url_length);
                report_field("major_version", want.major, major_version);
                report_field("minor_version", want.minor, minor_version);
                report_field("error_code", want.err, error_code);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Well-formed requests, case folding, empty URL, byte extremes, and the bad-method, URL-end and literal errors.
    task automatic test_directed();
        send_text("\r\nGET / HTTP/1.1\r\nHost: x\r\n\r\n");
        send_text("hEaD  hTtP/1.0\r\n\r\n");
        send_text("GET ");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text(" HTTP/");
        send_byte(8'h00);
        send_byte(hrhp_pkg::CH_DOT);
        send_byte(8'hFF);
        send_text("\r\n\r\n");
        // Bad method at idle, letter mismatch, latched method, missing space.
        send_text("xGEXHXGETX");
        // URL cut off by CR and by LF.
        send_text("GET ab\rHEAD a\n");
        // Literal mismatches: version word, dot, closing CR, closing LF.
        send_text("GET / HTTQGET / HTTP/1,GET / HTTP/1.1XGET / HTTP/1.1\rX");
    endtask

    // URL limit at zero, one, above the maximum, and one byte past a small limit.
    task automatic test_url_limits();
        set_url_limit(12'd0);
        send_text("GET a");
        set_url_limit(12'd1);
        send_text("GET a HTTP/1.1\r\n\r\nGET ab");
        // Register value above the maximum clamps to the maximum: a long URL still passes.
        set_url_limit(12'hFFF);
        send_text("GET ");
        repeat (40) send_byte(url_char());
        send_text(" HTTP/1.1\r\n\r\n");
        set_url_limit(12'd8);
        send_text("HEAD ");
        repeat (9) send_byte(url_char());
    endtask

    // Mostly well-formed requests with random content, plus noise and broken ones.
    task automatic test_random_traffic();
        int start;
        int pick;
        start = sent_bytes;
        while (sent_bytes - start < 500)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                set_url_limit(pick_url_limit());
            end
            else if (pick <= 2)
            begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_request(pick <= 5);
            end
        end
    endtask

    // Hold the receiver off while bytes keep coming, so the block fills and stalls
    // its input; then pause the sender until the block has drained.
    task automatic test_backpressure();
        idle_on     = 1'b0;
        hold_cycles = 300;
        repeat (6) send_request(1'b0);
        idle_on = 1'b1;
        wait_all_results();
    endtask

    // Closing traffic at full rate on both sides, default limit back in place.
    task automatic test_full_rate();
        set_url_limit(hrhp_pkg::URL_LIMIT_RESET);
        idle_on = 1'b0;
        repeat (8) send_request(1'b0);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        push            = 1'b0;
        byte_in         = '0;
        url_limit_we    = 1'b0;
        url_limit_wdata = '0;
        sent_bytes      = 0;
        mismatches      = 0;
        hold_cycles     = 0;
        idle_on         = 1'b1;
        phase_q         = P_IDLE;
        eol_q           = EOL_LF1;
        method_q        = hrhp_pkg::METHOD_GET;
        url_count_q     = '0;
        major_q         = '0;
        minor_q         = '0;
        url_limit_q     = hrhp_pkg::URL_LIMIT_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_url_limits();
        test_random_traffic();
        test_backpressure();
        test_full_rate();

        wait_all_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
